FILE: hdl/ppg_pkg.sv
// Package for the plasma pixel generator: sine ROM, rainbow palette and pipeline types.
package ppg_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned ColorW = 16;
  localparam int unsigned StageCount = 4;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [ColorW-1:0] color_t;

  typedef struct packed {
    coord_t idx_a;
    coord_t idx_b;
    coord_t idx_c;
  } idx_bundle_t;

  typedef struct packed {
    coord_t sin_a;
    coord_t sin_b;
    coord_t sin_c;
  } sin_bundle_t;

  // Quarter sine wave, entries 0..64 of floor((sin(2*pi*i/256) + 1) * 127.5).
  localparam logic [7:0] QUARTER_SINE [65] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
    8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd184,
    8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210,
    8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246,
    8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd255
  };

  // Full-wave sine lookup folded from the quarter table.
  function automatic coord_t sine_lookup(input coord_t idx);
    logic [6:0] k;
    logic [6:0] addr;
    logic [7:0] q;
    k = {1'b0, idx[5:0]};
    addr = idx[6] ? (7'd64 - k) : k;
    q = QUARTER_SINE[addr];
    if (idx[7]) begin
      if (q > 8'd254) begin
        q = 8'd254;
      end
      q = 8'd254 - q;
    end
    return q;
  endfunction

  // Piecewise-linear rainbow palette packed to RGB565.
  function automatic color_t rainbow565(input coord_t p);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] step4;
    logic [7:0] step8;
    step4 = {1'b0, p[4:0], 2'b00};
    step8 = {p[4:0], 3'b000};
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    unique case (p[7:5])
      3'd0: begin
        r = step4;
        b = 8'd128 - step4;
      end
      3'd1: begin
        r = 8'd128 + step4;
      end
      3'd2: begin
        r = 8'd255;
        g = step4;
      end
      3'd3: begin
        r = 8'd255;
        g = 8'd128 + step4;
      end
      3'd4: begin
        r = 8'd255 - step4;
        g = 8'd255;
        b = step4;
      end
      3'd5: begin
        r = 8'd128 - step4;
        g = 8'd255;
        b = 8'd255;
      end
      3'd6: begin
        g = 8'd255 - step4;
        b = 8'd255;
      end
      default: begin
        r = step8;
        g = step8;
        b = 8'd255;
      end
    endcase
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: hdl/plasma_pixel_generator.sv
// Plasma pixel generator: four-stage pipeline from coordinates and frame time to RGB565.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel request per beat:
//   in_pixel_x, in_pixel_y (coordinates, any 8-bit value) and in_frame_time.
//   Output channel out_valid/out_ready returns one RGB565 color per beat on
//   out_pixel_color, red in bits 15-11, green 10-5, blue 4-0.
//   Results come back in request order, exactly one per request.
// Throughput: one beat per clock, sustained, while out_ready stays high.
// Pipeline: one register per stage: stage 1 forms the three sine indices,
//   stage 2 reads the sine ROM three times, stage 3 adds the three sine
//   words mod 256, stage 4 looks up the palette and holds the output beat.
// Stalls: each stage advances when the next one is empty or advancing, so a
//   low out_ready holds the output beat and fills the empty stages behind it;
//   in_ready drops only when all four stages are full. Nothing is dropped or
//   repeated. With out_ready high, in_ready is high in the same cycle.
// Reset: synchronous, active low rst_n clears all stage valid bits; in_ready
//   is high and out_valid low from the first cycle after reset.
module plasma_pixel_generator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ppg_pkg::coord_t       in_pixel_x,
  input  ppg_pkg::coord_t       in_pixel_y,
  input  ppg_pkg::coord_t       in_frame_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ppg_pkg::color_t       out_pixel_color
);

  // Stage valid bits, stage 0 is index formation, stage 3 the output register.
  logic [ppg_pkg::StageCount-1:0] vld_r;
  logic [ppg_pkg::StageCount-1:0] vld_nxt;
  logic [ppg_pkg::StageCount-1:0] adv;

  ppg_pkg::idx_bundle_t idx_r;
  ppg_pkg::idx_bundle_t idx_nxt;
  ppg_pkg::sin_bundle_t sin_r;
  ppg_pkg::sin_bundle_t sin_nxt;
  ppg_pkg::coord_t      sum_r;
  ppg_pkg::coord_t      sum_nxt;
  ppg_pkg::color_t      color_r;
  ppg_pkg::color_t      color_nxt;

  // Frame-time multiples and the diagonal term.
  ppg_pkg::coord_t t3;
  ppg_pkg::coord_t t5;
  logic [ppg_pkg::CoordW:0] diag_sum;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    adv[ppg_pkg::StageCount-1] = !vld_r[ppg_pkg::StageCount-1] || out_ready;
    for (int i = ppg_pkg::StageCount - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  // Shift valid bits forward; a stage whose content leaves without refill clears.
  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < ppg_pkg::StageCount; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  // Stage 1: sine indices, all mod 256.
  always_comb begin
    t3 = in_frame_time + {in_frame_time[ppg_pkg::CoordW-2:0], 1'b0};
    t5 = in_frame_time + {in_frame_time[ppg_pkg::CoordW-3:0], 2'b00};
    diag_sum = {1'b0, in_pixel_x} + {1'b0, in_pixel_y};
    idx_nxt.idx_a = in_pixel_x + in_frame_time;
    idx_nxt.idx_b = in_pixel_y + t3;
    idx_nxt.idx_c = diag_sum[ppg_pkg::CoordW:1] + t5;
  end

  // Stage 2: three ROM reads.
  always_comb begin
    sin_nxt.sin_a = ppg_pkg::sine_lookup(idx_r.idx_a);
    sin_nxt.sin_b = ppg_pkg::sine_lookup(idx_r.idx_b);
    sin_nxt.sin_c = ppg_pkg::sine_lookup(idx_r.idx_c);
  end

  // Stage 3: wrap the sum to 8 bits.
  assign sum_nxt = sin_r.sin_a + sin_r.sin_b + sin_r.sin_c;

  // Stage 4: palette.
  assign color_nxt = ppg_pkg::rainbow565(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload registers load only when their stage advances.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      idx_r <= idx_nxt;
    end
    if (adv[1]) begin
      sin_r <= sin_nxt;
    end
    if (adv[2]) begin
      sum_r <= sum_nxt;
    end
    if (adv[3]) begin
      color_r <= color_nxt;
    end
  end

  assign out_valid       = vld_r[ppg_pkg::StageCount-1];
  assign out_pixel_color = color_r;

endmodule

FILE: hdl/ppg_checker.sv
// Port-level checker for the plasma pixel generator and its bind.
module ppg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ppg_pkg::color_t out_pixel_color
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled output beat holds its color.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_color))
    else $error("output beat changed while stalled");

  // A draining or empty output stage lets the whole pipeline accept.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("in_ready low while output stage can drain");

  // With the receiver ready, an accepted beat reaches the output without stalling.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted beat missing at output after four cycles");

endmodule

bind plasma_pixel_generator ppg_checker u_ppg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_color (out_pixel_color)
);

FILE: test/plasma_pixel_generator_tb.sv
// Self-checking testbench for the plasma pixel generator: sine sum, palette and handshakes.
`timescale 1ns / 100ps

module plasma_pixel_generator_tb;

  // One pending pixel request, tagged with the idling profile it runs under.
  typedef struct {
    ppg_pkg::coord_t x;
    ppg_pkg::coord_t y;
    ppg_pkg::coord_t t;
    int              profile;
  } pixel_req_t;

  // Idling profiles: sender idles 34% / receiver 66%, then swapped, then none.
  localparam int ProfSlowSink = 0;
  localparam int ProfSlowSrc  = 1;
  localparam int ProfFull     = 2;

  localparam int RandomPerProfile = 300;
  localparam int DrainCycles      = 12;

  // Quarter sine wave, floor((sin(2*pi*i/256) + 1) * 127.5) for i in 0..64.
  localparam logic [7:0] QSINE [65] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
    8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd184,
    8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210,
    8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246,
    8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd255
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  ppg_pkg::coord_t in_pixel_x = '0;
  ppg_pkg::coord_t in_pixel_y = '0;
  ppg_pkg::coord_t in_frame_time = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ppg_pkg::color_t out_pixel_color;

  pixel_req_t      pixel_req_q[$];
  ppg_pkg::color_t color_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int req_count = 0;
  int color_count = 0;
  int segment_hits [8];

  plasma_pixel_generator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_frame_time   (in_frame_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Full-wave sine word: mirror the second quarter, invert the lower half around 254.
  function automatic logic [7:0] sine_word(input logic [7:0] idx);
    int k;
    logic [7:0] q;
    k = int'(idx[5:0]);
    q = idx[6] ? QSINE[64 - k] : QSINE[k];
    if (idx[7]) begin
      q = (q > 8'd254) ? 8'd0 : 8'd254 - q;
    end
    return q;
  endfunction

  // Palette index: sum of the three sine terms, mod 256.
  function automatic logic [7:0] plasma_index(input ppg_pkg::coord_t x,
                                              input ppg_pkg::coord_t y,
                                              input ppg_pkg::coord_t t);
    int t3;
    int t5;
    int diag;
    int sum;
    t3 = (int'(t) * 3) & 255;
    t5 = (int'(t) * 5) & 255;
    // The diagonal sum is 9 bits wide before the shift.
    diag = (int'(x) + int'(y)) >> 1;
    sum = int'(sine_word(8'((int'(x) + int'(t)) & 255)))
        + int'(sine_word(8'((int'(y) + t3) & 255)))
        + int'(sine_word(8'((diag + t5) & 255)));
    return 8'(sum & 255);
  endfunction

  // Rainbow palette: eight 32-step segments, packed to RGB565.
  function automatic ppg_pkg::color_t rainbow_color(input logic [7:0] p);
    int pi;
    int r;
    int g;
    int b;
    pi = int'(p);
    r = 0;
    g = 0;
    b = 0;
    if (pi < 32) begin
      r = 4 * pi;
      b = 128 - 4 * pi;
    end else if (pi < 64) begin
      r = 128 + 4 * (pi - 32);
    end else if (pi < 96) begin
      r = 255;
      g = 4 * (pi - 64);
    end else if (pi < 128) begin
      r = 255;
      g = 128 + 4 * (pi - 96);
    end else if (pi < 160) begin
      r = 255 - 4 * (pi - 128);
      g = 255;
      b = 4 * (pi - 128);
    end else if (pi < 192) begin
      r = 128 - 4 * (pi - 160);
      g = 255;
      b = 255;
    end else if (pi < 224) begin
      g = 255 - 4 * (pi - 192);
      b = 255;
    end else begin
      r = 8 * (pi - 224);
      g = r;
      b = 255;
    end
    return {5'((r & 255) >> 3), 6'((g & 255) >> 2), 5'((b & 255) >> 3)};
  endfunction

  task automatic add_req(input int x, input int y, input int t, input int profile);
    pixel_req_t req;
    req.x = ppg_pkg::coord_t'(x);
    req.y = ppg_pkg::coord_t'(y);
    req.t = ppg_pkg::coord_t'(t);
    req.profile = profile;
    pixel_req_q.push_back(req);
  endtask

  // Driver: hold a beat until accepted, otherwise maybe idle, otherwise launch the next one.
  always @(posedge clk) begin
    pixel_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold the current beat
    end else if (pixel_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      req = pixel_req_q.pop_front();
      in_pixel_x <= req.x;
      in_pixel_y <= req.y;
      in_frame_time <= req.t;
      in_valid <= 1'b1;
      case (req.profile)
        ProfSlowSink: begin
          send_idle_pct <= 34;
          recv_idle_pct <= 66;
        end
        ProfSlowSrc: begin
          send_idle_pct <= 66;
          recv_idle_pct <= 34;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Monitor: predict on every accepted request, then check every accepted color beat.
  always @(posedge clk) begin
    logic [7:0] p;
    ppg_pkg::color_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        p = plasma_index(in_pixel_x, in_pixel_y, in_frame_time);
        segment_hits[p[7:5]]++;
        color_q.push_back(rainbow_color(p));
        req_count++;
      end
      if (out_valid && out_ready) begin
        color_count++;
        if (color_q.size() == 0) begin
          $display("%0t: unexpected color beat, expected none, got %04h",
                   $realtime, out_pixel_color);
          error_count++;
        end else begin
          want = color_q.pop_front();
          if (out_pixel_color !== want) begin
            $display("%0t: pixel_color mismatch, expected %04h, got %04h",
                     $realtime, want, out_pixel_color);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      out_ready <= 1'b0;
    end
  end

  initial begin
    int seg_seen;
    // Corners of the coordinate and frame ranges.
    add_req(0, 0, 0, ProfFull);
    add_req(255, 255, 255, ProfFull);
    add_req(255, 0, 0, ProfFull);
    add_req(0, 255, 0, ProfFull);
    add_req(0, 0, 255, ProfFull);
    // Diagonal term carries past 8 bits before the shift.
    add_req(255, 255, 0, ProfFull);
    add_req(200, 180, 0, ProfFull);
    add_req(129, 127, 0, ProfFull);
    // Triple and quintuple frame time wrap.
    add_req(0, 0, 86, ProfFull);
    add_req(0, 0, 52, ProfFull);
    add_req(17, 99, 171, ProfFull);
    add_req(3, 250, 205, ProfFull);
    add_req(1, 1, 128, ProfFull);
    // Sine fold points: quarter edges and the trough.
    add_req(63, 0, 0, ProfFull);
    add_req(64, 64, 0, ProfFull);
    add_req(128, 128, 0, ProfFull);
    add_req(192, 192, 0, ProfFull);
    add_req(191, 65, 0, ProfFull);
    // Coordinates beyond the visible screen compute the same way.
    add_req(200, 250, 17, ProfFull);
    add_req(170, 85, 85, ProfFull);
    for (int prof = ProfSlowSink; prof <= ProfFull; prof++) begin
      for (int n = 0; n < RandomPerProfile; n++) begin
        add_req($urandom_range(255), $urandom_range(255), $urandom_range(255), prof);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pixel_req_q.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (color_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    seg_seen = 0;
    foreach (segment_hits[i]) begin
      if (segment_hits[i] > 0) begin
        seg_seen++;
      end
    end
    $display("Sent %0d pixel requests under three idling profiles, checked %0d colors.",
             req_count, color_count);
    $display("Rainbow palette segments reached: %0d of 8.", seg_seen);
    if (error_count == 0) begin
      $display("[plasma_pixel_generator] OK");
    end else begin
      $display("[plasma_pixel_generator] ERROR");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under 10 us.
  initial begin
    #200000;
    $display("[plasma_pixel_generator] ERROR");
    $finish;
  end

endmodule
